// ----- src/udiv256_pkg.sv -----
// Shared types and constants for the 256-bit unsigned divider.
// Used by udiv256_ctrl, udiv256_dp and unsigned_divider_256_core.
`default_nettype none

package udiv256_pkg;

	localparam int unsigned WORD_W  = 64;
	localparam int unsigned OPND_W  = 256;
	localparam int unsigned CNT_W   = 8;
	localparam logic [CNT_W-1:0] CNT_LAST = 8'd255;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FINISH
	} udiv_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic step;
		logic capture;
	} udiv_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic special;
	} udiv_sts_t;

endpackage

`default_nettype wire

// ----- src/udiv256_dp.sv -----
// Datapath of the 256-bit divider: operand, partial remainder and output registers.
// Depends on udiv256_pkg; driven by udiv256_ctrl through udiv_cmd_t.
`default_nettype none

module udiv256_dp (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  udiv256_pkg::udiv_cmd_t              cmd,
	output udiv256_pkg::udiv_sts_t              sts,
	input  wire [2*udiv256_pkg::OPND_W-1:0]     in_data,
	output logic [udiv256_pkg::OPND_W-1:0]      quo_out,
	output logic [udiv256_pkg::OPND_W-1:0]      rem_out,
	output logic                                div0_out
);
	import udiv256_pkg::*;

	logic [OPND_W-1:0] in_num;
	logic [OPND_W-1:0] in_den;
	logic              num_zero;
	logic              den_zero;

	// num_q shifts dividend bits out at the top and quotient bits in at the bottom
	logic [OPND_W-1:0] num_q;
	logic [OPND_W-1:0] rem_q;
	logic [OPND_W-1:0] den_q;
	logic              div0_q;

	logic [OPND_W:0]   shifted;
	logic [OPND_W+1:0] diff;
	logic              take;

	logic [OPND_W-1:0] quo_out_q;
	logic [OPND_W-1:0] rem_out_q;
	logic              div0_out_q;

	assign in_num   = in_data[OPND_W-1:0];
	assign in_den   = in_data[2*OPND_W-1:OPND_W];
	assign num_zero = (in_num == '0);
	assign den_zero = (in_den == '0);
	assign sts.special = num_zero | den_zero;

	assign shifted = {rem_q, num_q[OPND_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, den_q};
	// no borrow means the shifted remainder reaches the divisor
	assign take    = ~diff[OPND_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			den_q      <= '0;
			div0_q     <= 1'b0;
			num_q      <= '0;
			rem_q      <= '0;
			quo_out_q  <= '0;
			rem_out_q  <= '0;
			div0_out_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				den_q  <= in_den;
				div0_q <= ~num_zero & den_zero;
				if (~num_zero & den_zero) begin
					num_q <= '0;
					rem_q <= in_num;
				end else begin
					num_q <= in_num;
					rem_q <= '0;
				end
			end else if (cmd.step) begin
				num_q <= {num_q[OPND_W-2:0], take};
				rem_q <= take ? diff[OPND_W-1:0] : shifted[OPND_W-1:0];
			end
			if (cmd.capture) begin
				quo_out_q  <= num_q;
				rem_out_q  <= rem_q;
				div0_out_q <= div0_q;
			end
		end
	end

	assign quo_out  = quo_out_q;
	assign rem_out  = rem_out_q;
	assign div0_out = div0_out_q;

endmodule

`default_nettype wire

// ----- src/udiv256_ctrl.sv -----
// Controller of the 256-bit divider: sequencer state, bit counter and output valid.
// Depends on udiv256_pkg; drives udiv256_dp through udiv_cmd_t.
`default_nettype none

module udiv256_ctrl (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      s_tvalid,
	output logic                     s_tready,
	output logic                     m_tvalid,
	input  wire                      m_tready,
	input  udiv256_pkg::udiv_sts_t   sts,
	output udiv256_pkg::udiv_cmd_t   cmd
);
	import udiv256_pkg::*;

	udiv_state_t       state_q;
	udiv_state_t       state_d;
	logic [CNT_W-1:0]  cnt_q;
	logic              out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = sts.special ? ST_FINISH : ST_RUN;
				end
			end
			ST_RUN: begin
				if (cnt_q == '0) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || m_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready    = 1'b0;
		cmd.load    = 1'b0;
		cmd.step    = 1'b0;
		cmd.capture = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			ST_RUN: begin
				cmd.step = 1'b1;
			end
			ST_FINISH: begin
				cmd.capture = !out_valid_q || m_tready;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				cnt_q <= CNT_LAST;
			end else if (cmd.step) begin
				cnt_q <= cnt_q - 1'b1;
			end
			// hold the word until taken; a new capture refills the register
			if (cmd.capture) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;

endmodule

`default_nettype wire

// ----- src/unsigned_divider_256_core.sv -----
// Top level of the 256-bit unsigned divider: stream ports, controller and datapath.
// Depends on udiv256_pkg, udiv256_ctrl and udiv256_dp.
//
// Usage:
//   Slave channel s_*: one word carries dividend and divisor, 256 bits each.
//   Master channel m_*: one word carries quotient and remainder; m_tuser[0]
//   flags a zero divisor with a nonzero dividend (quotient zero, remainder
//   equal to the dividend). A zero dividend returns zeros and no flag.
//   One word is worked on at a time by a radix-2 restoring divider that
//   settles one quotient bit per cycle with a single 258-bit subtract.
//   From acceptance the word is loaded, stepped once per quotient bit and then
//   captured into the output register, raising m_tvalid; a zero dividend or
//   divisor skips the steps. The bit-serial loop admits no new word till capture.
//   The result sits in an output register, so the next word is accepted and
//   computed while the previous one waits for m_tready; if the receiver still
//   stalls when the next result is done, the divider holds in its final state.
//   Reset (arst_n low) drops any word in flight and clears m_tvalid;
//   the block leaves reset idle with s_tready high.
`default_nettype none

module unsigned_divider_256_core (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_tvalid,
	output logic         s_tready,
	// dividend_w0, dividend_w1, dividend_w2, dividend_w3,
	// divisor_w0, divisor_w1, divisor_w2, divisor_w3
	input  wire  [511:0] s_tdata,
	output logic         m_tvalid,
	input  wire          m_tready,
	// quotient_w0, quotient_w1, quotient_w2, quotient_w3,
	// remainder_w0, remainder_w1, remainder_w2, remainder_w3
	output logic [511:0] m_tdata,
	// status
	output logic [0:0]   m_tuser
);
	import udiv256_pkg::*;

	udiv_cmd_t          cmd;
	udiv_sts_t          sts;
	logic [OPND_W-1:0]  quo;
	logic [OPND_W-1:0]  rem;
	logic               div0;

	udiv256_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	udiv256_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.in_data  (s_tdata),
		.quo_out  (quo),
		.rem_out  (rem),
		.div0_out (div0)
	);

	assign m_tdata = {rem, quo};
	assign m_tuser = div0;

	// never overwrite a result the receiver has not taken
	a_capture_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |-> (!m_tvalid || m_tready))
		else $error("result register overwritten while stalled");

	// one word at a time: no acceptance right after one
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second word accepted while busy");

	// divide-by-zero flag comes with a zero quotient and a nonzero remainder
	a_div0_result: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (quo == '0 && rem != '0))
		else $error("divide-by-zero result inconsistent");

endmodule

`default_nettype wire
